// ----- hw/rtl/sorted_priority_queue_defines.svh -----
// Assertion macros shared by the sorted priority queue RTL.
// Needs no other file; the checks compile away when SYNTHESIS is defined.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks cons in the same cycle as ante.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks cons in the cycle after ante.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/spq_pkg.sv -----
// Types and codes of the sorted priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package spq_pkg;

	localparam int PID_W  = 16;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;

	typedef enum logic [1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_REM = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [PID_W-1:0]    process_id;
		logic [PRIO_W-1:0]   prio;
	} req_t;

	typedef struct packed {
		logic [PID_W-1:0]    out_pid;
		logic [PRIO_W-1:0]   out_prio;
		status_t             status;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

endpackage

// ----- hw/rtl/sorted_priority_queue.sv -----
// Sorted priority queue of (process id, priority) entries, lowest priority value
// served first and first come first served among equal priorities. Each item is
// an enqueue, a dequeue of the front entry, or a removal of the first entry with
// a given process id, and yields exactly one result with status and occupancy.
// In the cycle an item is accepted every slot of the register array compares
// against it in parallel; once the result register is free, the array shifts
// and the result register loads. A new item is accepted once the previous one
// has committed, so the block does not take a new item before it is through
// with the last one; a waiting result does not block acceptance, only the
// next commit. No clearing pass runs after reset.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  spq_pkg::req_t    req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output spq_pkg::rsp_t    rsp
);

	spq_pkg::ctrl_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	spq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- hw/rtl/spq_ctrl.sv -----
// Controller of the sorted priority queue: handshakes and sequencing.
// Depends on spq_pkg and sorted_priority_queue_defines.svh.
`include "sorted_priority_queue_defines.svh"

module spq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output spq_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   load;
	logic   commit;

	assign req_stall = (state_q != S_IDLE);
	assign load      = req_valid && (state_q == S_IDLE);
	// The result register must be free, or be emptied in this same cycle.
	assign commit    = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.load   = load;
		cmd.commit = commit;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (load) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`SPQ_ASSERT_NXT(a_load_to_exec, clk, arst_n, load, state_q == S_EXEC)
	`SPQ_ASSERT_IMP(a_commit_free, clk, arst_n, commit, !(rsp_valid_q && rsp_stall))
	`SPQ_ASSERT_NXT(a_commit_shows, clk, arst_n, commit, rsp_valid_q && (state_q == S_IDLE))

endmodule

// ----- hw/rtl/spq_dpath.sv -----
// Datapath of the sorted priority queue: slot array, compare flags, shift and result register.
// Depends on spq_pkg and sorted_priority_queue_defines.svh.
`include "sorted_priority_queue_defines.svh"

module spq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spq_pkg::ctrl_cmd_t    cmd,
	input  spq_pkg::req_t         req,
	output spq_pkg::rsp_t         rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [DEPTH-1:0] LSB_ONE = DEPTH'(1);

	logic [spq_pkg::PRIO_W-1:0] slot_prio_q [DEPTH];
	logic [spq_pkg::PID_W-1:0]  slot_pid_q  [DEPTH];
	logic [CW-1:0]              count_q;

	spq_pkg::req_t              req_s1;
	logic [DEPTH-1:0]           le_s1;
	logic [DEPTH-1:0]           match_s1;
	spq_pkg::rsp_t              rsp_q;

	logic [DEPTH-1:0]           le_d;
	logic [DEPTH-1:0]           match_d;

	logic                       full;
	logic                       empty;
	logic                       found;
	logic                       do_ins;
	logic                       do_rem;
	logic [DEPTH-1:0]           rm_vec;
	logic [DEPTH-1:0]           rm_dec;
	logic [DEPTH-1:0]           rm_after;
	logic [DEPTH-1:0]           rm_first;
	logic [spq_pkg::PID_W-1:0]  sel_pid;
	logic [spq_pkg::PRIO_W-1:0] sel_prio;
	logic [CW-1:0]              count_d;
	spq_pkg::status_t           status_d;

	// Every slot compares against the incoming item in parallel.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			le_d[i]    = (CW'(i) < count_q) && (slot_prio_q[i] <= req.prio);
			match_d[i] = (CW'(i) < count_q) && (slot_pid_q[i] == req.process_id);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1   <= req;
			le_s1    <= le_d;
			match_s1 <= match_d;
		end
	end

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign found = |match_s1;

	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		status_d = spq_pkg::ST_OK;
		case (req_s1.action)
			spq_pkg::ACT_ENQ: begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			spq_pkg::ACT_DEQ: begin
				if (empty) begin
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					do_rem = 1'b1;
				end
			end
			spq_pkg::ACT_REM: begin
				if (!found) begin
					status_d = spq_pkg::ST_NOTFOUND;
				end else begin
					do_rem = 1'b1;
				end
			end
			default: begin
				status_d = spq_pkg::ST_OK;
			end
		endcase
	end

	// A dequeue is a removal whose only match is the front slot. The lowest
	// set bit marks the slot taken out, and every slot from there up moves down.
	assign rm_vec   = (req_s1.action == spq_pkg::ACT_DEQ) ? (empty ? '0 : LSB_ONE) : match_s1;
	assign rm_dec   = rm_vec - LSB_ONE;
	assign rm_after = ~(~rm_vec & rm_dec);
	assign rm_first = rm_vec & ~rm_dec;

	always_comb begin
		sel_pid  = '0;
		sel_prio = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rm_first[i]) begin
				sel_pid  = sel_pid | slot_pid_q[i];
				sel_prio = sel_prio | slot_prio_q[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_rem) begin
			count_d = count_q - CW'(1);
		end
	end

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_slot
		logic                       up_le;
		logic [spq_pkg::PRIO_W-1:0] up_prio;
		logic [spq_pkg::PID_W-1:0]  up_pid;
		logic [spq_pkg::PRIO_W-1:0] dn_prio;
		logic [spq_pkg::PID_W-1:0]  dn_pid;

		if (gi == 0) begin : g_head
			assign up_le   = 1'b1;
			assign up_prio = req_s1.prio;
			assign up_pid  = req_s1.process_id;
		end else begin : g_body
			assign up_le   = le_s1[gi-1];
			assign up_prio = slot_prio_q[gi-1];
			assign up_pid  = slot_pid_q[gi-1];
		end

		if (gi == DEPTH - 1) begin : g_tail
			assign dn_prio = slot_prio_q[gi];
			assign dn_pid  = slot_pid_q[gi];
		end else begin : g_inner
			assign dn_prio = slot_prio_q[gi+1];
			assign dn_pid  = slot_pid_q[gi+1];
		end

		// On insert, the first slot past the lower-or-equal run takes the new
		// item and the slots above it move up by one.
		always_ff @(posedge clk) begin
			if (cmd.commit) begin
				if (do_ins && !le_s1[gi]) begin
					slot_prio_q[gi] <= up_le ? req_s1.prio : up_prio;
					slot_pid_q[gi]  <= up_le ? req_s1.process_id : up_pid;
				end else if (do_rem && rm_after[gi]) begin
					slot_prio_q[gi] <= dn_prio;
					slot_pid_q[gi]  <= dn_pid;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.out_pid   <= do_rem ? sel_pid : '0;
			rsp_q.out_prio  <= do_rem ? sel_prio : '0;
			rsp_q.status    <= status_d;
			rsp_q.occupancy <= spq_pkg::OCC_W'(count_d);
		end
	end

	assign rsp = rsp_q;

	`SPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`SPQ_ASSERT_IMP(a_sorted, clk, arst_n, cmd.commit, (le_s1 & (le_s1 + LSB_ONE)) == '0)
	`SPQ_ASSERT_IMP(a_one_update, clk, arst_n, cmd.commit, !(do_ins && do_rem))

endmodule
